>>> hdl/hwsc_pkg.sv
// ---------------------------------------------------------------------------
// hwsc_pkg: shared types and constants of the Hamming word site counter
// Field widths, register index codes, the links between cells of the window
// row and the lookup of one word character from the two word registers.
// ---------------------------------------------------------------------------
`default_nettype none

package hwsc_pkg;

   localparam int WORD_MAX_DEF = 16;   // default number of window cells
   localparam int SYM_W        = 8;    // character width
   localparam int TOTAL_W      = 16;   // matched sequence count width
   localparam int CFG_W        = 5;    // width / minimum register width
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int WORD_CHARS   = 16;   // characters held by the word registers

   localparam logic [CSR_IDX_W-1:0] CSR_WORD_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_HIGH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MATCH = 8'd3;

   localparam logic [CFG_W-1:0] WIDTH_RESET     = 5'd8;
   localparam logic [CFG_W-1:0] MIN_MATCH_RESET = 5'd8;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 16'hFFFF;

   // one character handed from a cell to its older neighbor
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             valid;
   } link_type;

   // control common to the cell row
   typedef struct packed {
      logic shift;
      logic restart;
   } cell_ctrl_type;

   // word character idx; characters past the register pair read as zero
   function automatic logic [SYM_W-1:0] word_char(input logic [CSR_DATA_W-1:0] lo,
                                                  input logic [CSR_DATA_W-1:0] hi,
                                                  input int idx);
      logic [SYM_W-1:0] c;
      c = '0;
      if (idx >= 0 && idx < 8) begin
         c = lo[idx*SYM_W +: SYM_W];
      end else if (idx >= 8 && idx < WORD_CHARS) begin
         c = hi[(idx-8)*SYM_W +: SYM_W];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/hamming_word_site_counter.sv
// ---------------------------------------------------------------------------
// hamming_word_site_counter: approximate word site counter (Hamming)
// Scans sequences for windows within a mismatch allowance of a set word.
// ---------------------------------------------------------------------------
// One character beat is taken every cycle while req_ready is high. Characters enter a row of
// WORD_MAX cells that shift one place per accepted beat, so the row always
// holds the newest characters of the current sequence; each cell compares
// its character with the word character for its place. The compare vector
// is registered, its equal positions are counted and checked against the
// minimum, and at a sequence end the result beat is written to an output
// register. A beat carrying end_of_sequence goes through the cell row and the
// compare register first. Input is held back only while a result still sits
// unclaimed in the output register and the next result is ready behind it.
// Configuration writes are always taken (csr_ready is high) and take effect
// on the next cycle; write them only while no sequence result is pending.
// ---------------------------------------------------------------------------
`default_nettype none

module hamming_word_site_counter
   import hwsc_pkg::*;
#(
   parameter int WORD_MAX = WORD_MAX_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [SYM_W-1:0]      req_symbol,
   input  wire logic                  req_end_of_sequence,
   input  wire logic                  req_end_of_set,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_sequence_matched,
   output      logic [TOTAL_W-1:0]    rsp_matched_count,
   output      logic                  rsp_set_done,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CntW = $clog2(WORD_MAX + 1);

   logic [CSR_DATA_W-1:0] word_lo_ff, word_hi_ff;
   logic [CFG_W-1:0]      width_ff, min_ff;

   logic                accept;
   logic                seq_start_ff;
   logic [CntW-1:0]     width_eff;
   logic [WORD_MAX-1:0] eq_vec;
   logic                full;
   link_type            link [WORD_MAX];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_lo_ff <= '0;
         word_hi_ff <= '0;
         width_ff   <= WIDTH_RESET;
         min_ff     <= MIN_MATCH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WORD_LOW:  word_lo_ff <= csr_wdata;
            CSR_WORD_HIGH: word_hi_ff <= csr_wdata;
            CSR_WIDTH:     width_ff   <= csr_wdata[CFG_W-1:0];
            CSR_MIN_MATCH: min_ff     <= csr_wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the width to 1 .. WORD_MAX
   always_comb begin
      if (width_ff == '0) begin
         width_eff = CntW'(1);
      end else if (int'(width_ff) > WORD_MAX) begin
         width_eff = CntW'(WORD_MAX);
      end else begin
         width_eff = CntW'(width_ff);
      end
   end

   // mark the first beat of each sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_start_ff <= 1'b1;
      end else if (accept) begin
         seq_start_ff <= req_end_of_sequence;
      end
   end

   for (genvar k = 0; k < WORD_MAX; k++) begin : g_cell
      cell_ctrl_type    ctrl;
      link_type         link_in;
      logic [SYM_W-1:0] cmp_char;
      logic             cmp_en;

      // the oldest window character meets word character 0
      assign cmp_en   = k < int'(width_eff);
      assign cmp_char = word_char(word_lo_ff, word_hi_ff, int'(width_eff) - 1 - k);
      assign ctrl     = '{shift: accept, restart: (k != 0) && seq_start_ff};

      if (k == 0) begin : g_head
         assign link_in = '{symbol: req_symbol, valid: 1'b1};
      end else begin : g_body
         assign link_in = link[k-1];
      end

      hwsc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .link_in  (link_in),
         .link_out (link[k]),
         .cmp_char (cmp_char),
         .cmp_en   (cmp_en),
         .eq       (eq_vec[k])
      );
   end

   // full window once the cell at the word's oldest place is filled
   always_comb begin
      full = 1'b0;
      for (int k = 0; k < WORD_MAX; k++) begin
         if (k == int'(width_eff) - 1) begin
            full = link[k].valid;
         end
      end
   end

   hwsc_tally #(
      .WORD_MAX (WORD_MAX)
   ) u_tally (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_end_of_sequence  (req_end_of_sequence),
      .req_end_of_set       (req_end_of_set),
      .accept               (accept),
      .eq_vec               (eq_vec),
      .full                 (full),
      .width_eff            (width_eff),
      .min_match            (min_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sequence_matched (rsp_sequence_matched),
      .rsp_matched_count    (rsp_matched_count),
      .rsp_set_done         (rsp_set_done)
   );

endmodule

`default_nettype wire

>>> hdl/hwsc_cell.sv
// ---------------------------------------------------------------------------
// hwsc_cell: one position of the character window
// Holds one character and its fill flag, passes them to the next older cell
// on every shift and compares the held character with its word character.
// ---------------------------------------------------------------------------
`default_nettype none

module hwsc_cell
   import hwsc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctrl_type    ctrl,
   input  wire link_type         link_in,
   output      link_type         link_out,
   input  wire logic [SYM_W-1:0] cmp_char,
   input  wire logic             cmp_en,
   output      logic             eq
);

   logic [SYM_W-1:0] symbol_ff;
   logic             valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         // a new sequence empties every cell behind the newest one
         valid_ff <= link_in.valid & ~ctrl.restart;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         symbol_ff <= link_in.symbol;
      end
   end

   assign link_out = '{symbol: symbol_ff, valid: valid_ff};
   assign eq       = cmp_en && (symbol_ff == cmp_char);

endmodule

`default_nettype wire

>>> hdl/hwsc_tally.sv
// ---------------------------------------------------------------------------
// hwsc_tally: flow control, window score and per-set count
// Registers the compare vector of the cell row, counts equal positions,
// keeps the per-sequence site flag and the saturating set count, and holds
// the result beat in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hwsc_tally
   import hwsc_pkg::*;
#(
   parameter int WORD_MAX = WORD_MAX_DEF,
   localparam int CntW = $clog2(WORD_MAX + 1),
   localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_end_of_sequence,
   input  wire logic               req_end_of_set,
   output      logic               accept,
   input  wire logic [WORD_MAX-1:0] eq_vec,
   input  wire logic               full,
   input  wire logic [CntW-1:0]    width_eff,
   input  wire logic [CFG_W-1:0]   min_match,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_sequence_matched,
   output      logic [TOTAL_W-1:0] rsp_matched_count,
   output      logic               rsp_set_done
);

   // stage 0: tags of the character now in the cell row
   logic s0_valid_ff, s0_eos_ff, s0_eset_ff;
   // stage 1: compare vector
   logic                s1_valid_ff, s1_eos_ff, s1_eset_ff, s1_full_ff;
   logic [WORD_MAX-1:0] s1_eq_ff;
   logic                site_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic                rsp_valid_ff, rsp_matched_ff, rsp_set_done_ff;
   logic [TOTAL_W-1:0]  rsp_count_ff;

   logic               out_free, s1_move, s1_free, s0_move, s0_free;
   logic [CntW-1:0]    equal_cnt;
   logic               hit, site_now;
   logic [TOTAL_W-1:0] total_in;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_move  = s1_valid_ff && (!s1_eos_ff || out_free);
   assign s1_free  = !s1_valid_ff || s1_move;
   assign s0_move  = s0_valid_ff && s1_free;
   assign s0_free  = !s0_valid_ff || s0_move;
   assign req_ready = s0_free;
   assign accept    = req_valid && s0_free;

   always_comb begin
      equal_cnt = '0;
      for (int k = 0; k < WORD_MAX; k++) begin
         equal_cnt = equal_cnt + CntW'(s1_eq_ff[k]);
      end
   end

   assign hit = s1_full_ff &&
                ((CmpW'(min_match) > CmpW'(width_eff)) ||
                 (CmpW'(equal_cnt) >= CmpW'(min_match)));
   assign site_now = site_ff | hit;
   assign total_in = (site_now && total_ff != TOTAL_MAX) ? total_ff + 1'b1 : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         site_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s0_valid_ff <= 1'b1;
         end else if (s0_move) begin
            s0_valid_ff <= 1'b0;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s1_move) begin
            site_ff <= s1_eos_ff ? 1'b0 : site_now;
            if (s1_eos_ff) begin
               total_ff <= s1_eset_ff ? '0 : total_in;
            end
         end
         if (s1_move && s1_eos_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_eos_ff  <= req_end_of_sequence;
         s0_eset_ff <= req_end_of_set;
      end
      if (s1_free) begin
         s1_eos_ff  <= s0_eos_ff;
         s1_eset_ff <= s0_eset_ff;
         s1_full_ff <= full;
         s1_eq_ff   <= eq_vec;
      end
      if (s1_move && s1_eos_ff) begin
         rsp_matched_ff  <= site_now;
         rsp_count_ff    <= total_in;
         rsp_set_done_ff <= s1_eset_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sequence_matched = rsp_matched_ff;
   assign rsp_matched_count    = rsp_count_ff;
   assign rsp_set_done         = rsp_set_done_ff;

endmodule

`default_nettype wire

>>> hdl/hwsc_checker.sv
// ---------------------------------------------------------------------------
// hwsc_checker: port-level checks of the Hamming word site counter
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module hwsc_checker
   import hwsc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_sequence_matched,
   input wire logic [TOTAL_W-1:0]    rsp_matched_count,
   input wire logic                  rsp_set_done
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched_count)
         && $stable(rsp_sequence_matched) && $stable(rsp_set_done))
      else $error("result beat changed while stalled");

   // a matched sequence is always counted
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_matched |-> rsp_matched_count != '0)
      else $error("matched sequence with zero count");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // with the result register empty the input side is open
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held back with no result pending");

endmodule

bind hamming_word_site_counter hwsc_checker u_hwsc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_sequence_matched (rsp_sequence_matched),
   .rsp_matched_count    (rsp_matched_count),
   .rsp_set_done         (rsp_set_done)
);

`default_nettype wire

>>> test/hamming_word_site_counter_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hamming_word_site_counter_tb: self-checking bench of the word site counter
// Streams sequence characters through the block under random idling on both
// sides, predicts every sequence verdict in the bench, and compares each
// result beat field by field. Settings are rewritten between phases once
// the block has drained.
// ---------------------------------------------------------------------------

module hamming_word_site_counter_tb;
   import hwsc_pkg::*;

   localparam int WINDOW_CELLS  = WORD_MAX_DEF;
   localparam int IDLE_PCT      = 24;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 50000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_CHARS   = 250;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_MIN_MATCH + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = '1;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_sequence;
      logic             end_of_set;
   } char_beat_type;

   typedef struct packed {
      logic               sequence_matched;
      logic [TOTAL_W-1:0] matched_count;
      logic               set_done;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SYM_W-1:0]      req_symbol = '0;
   logic                  req_end_of_sequence = 1'b0;
   logic                  req_end_of_set = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_sequence_matched;
   logic [TOTAL_W-1:0]    rsp_matched_count;
   logic                  rsp_set_done;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   char_beat_type chars_to_send [$];
   verdict_type   sequence_verdicts [$];
   int            chars_queued = 0;
   int            chars_taken = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            steady_flow = 1'b0;

   // bench copy of the window state and the settings
   logic [SYM_W-1:0]      hist_q [WINDOW_CELLS] = '{default: '0};
   int unsigned           chars_in_seq = 0;
   bit                    site_seen = 1'b0;
   logic [TOTAL_W-1:0]    set_total = '0;
   logic [CSR_DATA_W-1:0] word_lo = '0;
   logic [CSR_DATA_W-1:0] word_hi = '0;
   logic [CFG_W-1:0]      width_reg = WIDTH_RESET;
   logic [CFG_W-1:0]      min_reg = MIN_MATCH_RESET;
   logic [SYM_W-1:0]      alphabet [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

   hamming_word_site_counter #(
      .WORD_MAX(WINDOW_CELLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_symbol(req_symbol),
      .req_end_of_sequence(req_end_of_sequence),
      .req_end_of_set(req_end_of_set),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sequence_matched(rsp_sequence_matched),
      .rsp_matched_count(rsp_matched_count),
      .rsp_set_done(rsp_set_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned active_width();
      if (width_reg == '0) return 1;
      if (width_reg > WINDOW_CELLS) return WINDOW_CELLS;
      return width_reg;
   endfunction

   // shift one character in; return 1 with the verdict when it ends a sequence
   function automatic bit scan_symbol(input char_beat_type b, output verdict_type v);
      int unsigned w;
      int unsigned same;
      logic [2*CSR_DATA_W-1:0] word_bits;
      w = active_width();
      word_bits = {word_hi, word_lo};
      v = '0;
      for (int i = WINDOW_CELLS - 1; i > 0; i--) begin
         hist_q[i] = hist_q[i-1];
      end
      hist_q[0] = b.symbol;
      if (chars_in_seq < WINDOW_CELLS) chars_in_seq++;
      if (chars_in_seq >= w) begin
         same = 0;
         // oldest character in the window lines up with word character 0
         for (int k = 0; k < w; k++) begin
            if (hist_q[w-1-k] == word_bits[k*SYM_W +: SYM_W]) same++;
         end
         if (min_reg > w || same >= min_reg) site_seen = 1'b1;
      end
      if (!b.end_of_sequence) return 1'b0;
      if (site_seen && set_total != TOTAL_MAX) set_total++;
      v.sequence_matched = site_seen;
      v.matched_count = set_total;
      v.set_done = b.end_of_set;
      chars_in_seq = 0;
      site_seen = 1'b0;
      hist_q = '{default: '0};
      if (b.end_of_set) set_total = '0;
      return 1'b1;
   endfunction

   function automatic void report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT) $display("mismatch: %s", what);
      mismatch_count++;
   endfunction

   // driver: advance to the next queued character once the current beat is taken
   always @(posedge clock) begin : drive_chars
      char_beat_type nxt;
      char_beat_type cur;
      verdict_type   v;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.symbol = req_symbol;
            cur.end_of_sequence = req_end_of_sequence;
            cur.end_of_set = req_end_of_set;
            chars_taken++;
            if (scan_symbol(cur, v)) sequence_verdicts.insert(sequence_verdicts.size(), v);
         end
         if (!req_valid || req_ready) begin
            if (chars_to_send.size() != 0 &&
                (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = chars_to_send.pop_front();
               req_valid <= 1'b1;
               req_symbol <= nxt.symbol;
               req_end_of_sequence <= nxt.end_of_sequence;
               req_end_of_set <= nxt.end_of_set;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest predicted verdict
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sequence_verdicts.size() == 0) begin
               report_mismatch($sformatf("result beat with none expected: matched %0d count %0d done %0d",
                                         rsp_sequence_matched, rsp_matched_count, rsp_set_done));
            end else begin
               want = sequence_verdicts.pop_front();
               if (rsp_sequence_matched !== want.sequence_matched)
                  report_mismatch($sformatf("sequence_matched expected %0d got %0d",
                                            want.sequence_matched, rsp_sequence_matched));
               if (rsp_matched_count !== want.matched_count)
                  report_mismatch($sformatf("matched_count expected %0d got %0d",
                                            want.matched_count, rsp_matched_count));
               if (rsp_set_done !== want.set_done)
                  report_mismatch($sformatf("set_done expected %0d got %0d",
                                            want.set_done, rsp_set_done));
            end
         end
         rsp_ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_char(input logic [SYM_W-1:0] sym, input bit eos, input bit eset);
      char_beat_type b;
      b.symbol = sym;
      b.end_of_sequence = eos;
      b.end_of_set = eset;
      chars_to_send.insert(chars_to_send.size(), b);
      chars_queued++;
   endtask

   // hold until every character is taken and every verdict is back, then let
   // the pipeline empty behind characters that carry no result
   task automatic wait_idle();
      while (chars_taken != chars_queued || sequence_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes keep one assignment per step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WORD_LOW:  word_lo = data;
         CSR_WORD_HIGH: word_hi = data;
         CSR_WIDTH:     width_reg = data[CFG_W-1:0];
         CSR_MIN_MATCH: min_reg = data[CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic random_config(input int phase);
      int unsigned w;
      int unsigned ew;
      int unsigned m;
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      logic [CSR_DATA_W-1:0] data;
      for (int a = 0; a < 4; a++) alphabet[a] = SYM_W'($urandom_range(0, 255));
      for (int k = 0; k < 8; k++) begin
         lo[k*SYM_W +: SYM_W] = SYM_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : alphabet[$urandom_range(0, 3)]);
         hi[k*SYM_W +: SYM_W] = SYM_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : alphabet[$urandom_range(0, 3)]);
      end
      write_reg(CSR_WORD_LOW, lo);
      write_reg(CSR_WORD_HIGH, hi);
      if (phase == 0) w = WINDOW_CELLS;
      else if (phase == 1) w = 31;
      else if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 31);
      else w = $urandom_range(2, 12);
      // random upper bits check that only the low field is kept
      data = {$urandom(), $urandom()};
      data[CFG_W-1:0] = CFG_W'(w);
      write_reg(CSR_WIDTH, data);
      ew = active_width();
      if (phase < 2) m = WINDOW_CELLS;
      else if ($urandom_range(0, 7) == 0) m = $urandom_range(0, 31);
      else begin
         m = $urandom_range(0, 2);
         m = (m > ew) ? 0 : ew - m;
      end
      data = {$urandom(), $urandom()};
      data[CFG_W-1:0] = CFG_W'(m);
      write_reg(CSR_MIN_MATCH, data);
      if ($urandom_range(0, 1) == 0)
         write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                   {$urandom(), $urandom()});
   endtask

   // one sequence of alphabet characters with some noise; half of those as long as
   // the word carry a copy of it with up to two positions overwritten
   task automatic add_sequence(input int len, input bit close_set);
      int unsigned w;
      int at;
      logic [SYM_W-1:0] seq [$];
      logic [2*CSR_DATA_W-1:0] word_bits;
      w = active_width();
      word_bits = {word_hi, word_lo};
      for (int i = 0; i < len; i++) begin
         seq.insert(seq.size(), SYM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : alphabet[$urandom_range(0, 3)]));
      end
      if (len >= w && $urandom_range(0, 1) == 1) begin
         at = $urandom_range(0, len - w);
         for (int k = 0; k < w; k++) seq[at+k] = word_bits[k*SYM_W +: SYM_W];
         repeat ($urandom_range(0, 2)) seq[at + $urandom_range(0, w - 1)] = alphabet[$urandom_range(0, 3)];
      end
      for (int i = 0; i < len; i++) begin
         push_char(seq[i], i == len - 1,
                   (i == len - 1) ? close_set : ($urandom_range(0, 19) == 0));
      end
   endtask

   initial begin : run_stimulus
      int len;
      int chars;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: short sequences never match, a lone set end is ignored
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(8'h00, 1'b0, 1'b1);
      push_char(8'h00, 1'b1, 1'b1);
      wait_idle();

      // zero width acts as one; writes past the register list are dropped
      write_reg(CSR_WORD_LOW, 64'h0000_0000_0000_00FF);
      write_reg(CSR_WORD_HIGH, '1);
      write_reg(CSR_WIDTH, '0);
      write_reg(CSR_MIN_MATCH, 64'd1);
      write_reg(CSR_SPARE_LAST, '1);
      csr_valid <= 1'b0;
      push_char(8'hFF, 1'b1, 1'b0);
      push_char(8'h00, 1'b1, 1'b0);
      push_char(8'h00, 1'b0, 1'b0);
      push_char(8'hFF, 1'b1, 1'b1);
      wait_idle();

      // minimum above width: any full window matches
      write_reg(CSR_WIDTH, 64'd2);
      write_reg(CSR_MIN_MATCH, '1);
      csr_valid <= 1'b0;
      push_char(8'h12, 1'b0, 1'b0);
      push_char(8'h34, 1'b1, 1'b0);
      push_char(8'h56, 1'b1, 1'b1);
      wait_idle();

      // minimum zero: any full window matches, short sequences still do not
      write_reg(CSR_WIDTH, 64'd3);
      write_reg(CSR_MIN_MATCH, '0);
      csr_valid <= 1'b0;
      push_char(8'hAB, 1'b0, 1'b0);
      push_char(8'hCD, 1'b0, 1'b0);
      push_char(8'hEF, 1'b1, 1'b0);
      push_char(8'h01, 1'b0, 1'b0);
      push_char(8'h02, 1'b1, 1'b1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_config(p);
         csr_valid <= 1'b0;
         steady_flow = (p == 2);
         chars = 0;
         while (chars < PHASE_CHARS) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 40);
            else len = $urandom_range(1, active_width() + 6);
            add_sequence(len, $urandom_range(0, 4) == 0);
            chars += len;
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/hwsc_pkg.sv
hdl/hwsc_cell.sv
hdl/hwsc_tally.sv
hdl/hamming_word_site_counter.sv
hdl/hwsc_checker.sv
test/hamming_word_site_counter_tb.sv
